// ----- design/sbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbrf_pkg
// Shared types and constants for the symbol box relation features block.
// ----------------------------------------------------------------------------
`default_nettype none
package sbrf_pkg;

  localparam int COORD_WIDTH_DEF       = 16;
  localparam int MAX_POINTS_DEF        = 4096;
  localparam int FEATURE_FRAC_BITS_DEF = 8;
  localparam int COORD_FRAC            = 4;
  localparam int FEAT_W                = 16;
  localparam int NUM_FEAT              = 9;

  localparam logic [1:0] CLS_MEAN    = 2'd0;
  localparam logic [1:0] CLS_ASCEND  = 2'd1;
  localparam logic [1:0] CLS_DESCEND = 2'd2;
  localparam logic [1:0] CLS_MIDDLE  = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] point_x;
    logic signed [COORD_WIDTH_DEF-1:0] point_y;
    logic                              slot;
    logic [1:0]                        symbol_class;
    logic                              last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] height_ratio;
    logic signed [15:0] centroid_offset;
    logic signed [15:0] half_width_difference;
    logic signed [15:0] horizontal_gap;
    logic signed [15:0] left_offset;
    logic signed [15:0] right_offset;
    logic signed [15:0] vertical_gap;
    logic signed [15:0] low_edge_offset;
    logic signed [15:0] high_edge_offset;
    logic               zero_height;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic point;      // accumulate the held point
    logic mean_start; // start mean divider
    logic cent_store; // blend and store centroid, clear accumulator
    logic feat_load;  // latch feature k operands, start divider
    logic feat_store; // store feature k
    logic emit;       // drive result, reset state
  } sbrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic last;
    logic slot;
  } sbrf_sts_t;

endpackage
`default_nettype wire

// ----- design/sbrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbrf_ctrl
// Sequencer: point update, centroid division, nine feature divisions, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module sbrf_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  sbrf_pkg::sbrf_sts_t sts,
  output sbrf_pkg::sbrf_cmd_t cmd,
  output logic [3:0]          feat_idx
);
  import sbrf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POINT  = 3'd1;
  localparam logic [2:0] S_MEAN   = 3'd2;
  localparam logic [2:0] S_CENT   = 3'd3;
  localparam logic [2:0] S_FLOAD  = 3'd4;
  localparam logic [2:0] S_FDIV   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_MSTART = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign feat_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_POINT;
      end
      S_POINT: begin
        cmd.point = 1'b1;
        if (sts.last) begin
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // accumulator now holds the last point
      S_MSTART: begin
        cmd.mean_start = 1'b1;
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        if (sts.div_done) state_nxt = S_CENT;
      end
      S_CENT: begin
        cmd.cent_store = 1'b1;
        idx_nxt = '0;
        state_nxt = sts.slot ? S_FLOAD : S_IDLE;
      end
      S_FLOAD: begin
        cmd.feat_load = 1'b1;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (sts.div_done) begin
          cmd.feat_store = 1'b1;
          if (idx_r == 4'(NUM_FEAT - 1)) begin
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_r + 4'd1;
            state_nxt = S_FLOAD;
          end
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/sbrf_div.sv -----
// ----------------------------------------------------------------------------
// sbrf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sbrf_div #(
  parameter int W = 48
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          go,
  input  wire  [W-1:0] num,
  input  wire  [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]} - {1'b0, den_r};
    if (go) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (go) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ----- design/sbrf_dp.sv -----
// ----------------------------------------------------------------------------
// sbrf_dp
// Box, accumulator and centroid registers, operand selection and rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module sbrf_dp #(
  parameter int MAX_POINTS        = sbrf_pkg::MAX_POINTS_DEF,
  parameter int FEATURE_FRAC_BITS = sbrf_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  sbrf_pkg::in_item_t  in_item,
  input  sbrf_pkg::sbrf_cmd_t cmd,
  input  wire  [3:0]          feat_idx,
  output sbrf_pkg::sbrf_sts_t sts,
  output sbrf_pkg::out_item_t out_item
);
  import sbrf_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int SW = CW + NW + 1;
  localparam int DW = SW + 2 > CW + FEATURE_FRAC_BITS + 4 ? SW + 2
                                                          : CW + FEATURE_FRAC_BITS + 4;
  localparam logic signed [CW-1:0] POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] NEG = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] minx_r [2], maxx_r [2], miny_r [2], maxy_r [2], cent_r [2];
  logic signed [SW-1:0] ysum_r;
  logic [NW-1:0]        cnt_r;
  in_item_t             it_r;
  logic                 neg_r, zero_r;
  logic [FEAT_W-1:0]    feat_r [NUM_FEAT];

  logic signed [CW-1:0] px, py;
  logic                 s;
  assign px = it_r.point_x[CW-1:0];
  assign py = it_r.point_y[CW-1:0];
  assign s  = it_r.slot;

  // divider
  logic          dgo, ddone;
  logic [DW-1:0] dnum, dden, dquo;
  sbrf_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  // mean: floor((2 sum + n) / 2n) via magnitude division
  logic signed [SW+1:0] mnum;
  logic                 mneg_r;
  assign mnum = ((SW+2)'(ysum_r) <<< 1) + (SW+2)'($signed({1'b0, cnt_r}));

  // joint height and feature operands
  logic signed [CW+2:0] top, bot, h, fnum;
  logic signed [CW-1:0] sminx0, smaxx0, sminy0, smaxy0;
  always_comb begin
    top = (CW+3)'(maxy_r[0] > maxy_r[1] ? maxy_r[0] : maxy_r[1]);
    bot = (CW+3)'(miny_r[0] < miny_r[1] ? miny_r[0] : miny_r[1]);
    h   = top - bot;
    sminx0 = minx_r[0]; smaxx0 = maxx_r[0]; sminy0 = miny_r[0]; smaxy0 = maxy_r[0];
    case (feat_idx)
      4'd0: fnum = (CW+3)'(maxy_r[1]) - (CW+3)'(miny_r[1]) + (CW+3)'(1 << COORD_FRAC);
      4'd1: fnum = (CW+3)'(cent_r[0]) - (CW+3)'(cent_r[1]);
      4'd2: fnum = ((CW+3)'(smaxx0) - (CW+3)'(sminx0))
                 - ((CW+3)'(maxx_r[1]) - (CW+3)'(minx_r[1]));
      4'd3: fnum = (CW+3)'(minx_r[1]) - (CW+3)'(smaxx0);
      4'd4: fnum = (CW+3)'(minx_r[1]) - (CW+3)'(sminx0);
      4'd5: fnum = (CW+3)'(maxx_r[1]) - (CW+3)'(smaxx0);
      4'd6: fnum = (CW+3)'(miny_r[1]) - (CW+3)'(smaxy0);
      4'd7: fnum = (CW+3)'(miny_r[1]) - (CW+3)'(sminy0);
      default: fnum = (CW+3)'(maxy_r[1]) - (CW+3)'(smaxy0);
    endcase
  end

  logic [CW+2:0] fmag;
  logic [CW+2:0] dh;
  assign fmag = fnum[CW+2] ? (CW+3)'(-fnum) : fnum;
  assign dh   = (feat_idx == 4'd2) ? (CW+3)'(h <<< 1) : h;

  always_comb begin
    dgo  = cmd.mean_start | cmd.feat_load;
    dnum = '0;
    dden = '0;
    if (cmd.mean_start) begin
      // floor division of signed by positive: magnitude, then fix up
      if (mnum[SW+1])
        dnum = DW'($unsigned(-mnum)) + DW'(2) * DW'(cnt_r) - DW'(1);
      else
        dnum = DW'($unsigned(mnum));
      dden = DW'(cnt_r) << 1;
    end else begin
      // round half away: (2 mag 2^F + d) / 2d
      dnum = (DW'(fmag) << (FEATURE_FRAC_BITS + 1)) + DW'(dh);
      dden = DW'(dh) << 1;
    end
  end

  // centroid blend
  logic signed [CW:0]   mean, blend;
  logic signed [CW-1:0] cnew;
  always_comb begin
    if (cnt_r == '0) mean = '0;
    else if (mneg_r) mean = -(CW+1)'($signed(dquo[CW:0]));
    else mean = (CW+1)'($signed(dquo[CW:0]));
    case (it_r.symbol_class)
      CLS_ASCEND:  blend = (mean + (CW+1)'(maxy_r[s])) >>> 1;
      CLS_DESCEND: blend = (mean + (CW+1)'(miny_r[s])) >>> 1;
      CLS_MIDDLE:  blend = ((CW+1)'(miny_r[s]) + (CW+1)'(maxy_r[s])) >>> 1;
      default:     blend = mean;
    endcase
    cnew = blend[CW-1:0];
  end

  // saturated feature
  logic [FEAT_W-1:0] fsat;
  always_comb begin
    if (dquo > DW'(32767) + DW'(neg_r))
      fsat = neg_r ? 16'h8000 : 16'h7fff;
    else if (neg_r)
      fsat = 16'(-dquo[FEAT_W-1:0]);
    else
      fsat = dquo[FEAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) it_r <= in_item;
    if (cmd.mean_start) mneg_r <= mnum[SW+1];
    if (cmd.feat_load) begin
      neg_r  <= fnum[CW+2];
      zero_r <= (h <= 0);
    end
    if (cmd.feat_store)
      feat_r[feat_idx] <= zero_r ? '0 : fsat;
    if (!rst_n || cmd.emit) begin
      for (int i = 0; i < 2; i++) begin
        minx_r[i] <= POS; miny_r[i] <= POS;
        maxx_r[i] <= NEG; maxy_r[i] <= NEG;
        cent_r[i] <= '0;
      end
      ysum_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.point) begin
        if (px < minx_r[s]) minx_r[s] <= px;
        if (px > maxx_r[s]) maxx_r[s] <= px;
        if (py < miny_r[s]) miny_r[s] <= py;
        if (py > maxy_r[s]) maxy_r[s] <= py;
        if (cnt_r < NW'(MAX_POINTS)) begin
          ysum_r <= ysum_r + SW'(py);
          cnt_r  <= cnt_r + NW'(1);
        end
      end
      if (cmd.cent_store) begin
        cent_r[s] <= cnew;
        ysum_r <= '0;
        cnt_r  <= '0;
      end
    end
  end

  assign sts.div_done = ddone;
  assign sts.last     = it_r.last_point;
  assign sts.slot     = s;

  always_comb begin
    out_item.height_ratio          = feat_r[0];
    out_item.centroid_offset       = feat_r[1];
    out_item.half_width_difference = feat_r[2];
    out_item.horizontal_gap        = feat_r[3];
    out_item.left_offset           = feat_r[4];
    out_item.right_offset          = feat_r[5];
    out_item.vertical_gap          = feat_r[6];
    out_item.low_edge_offset       = feat_r[7];
    out_item.high_edge_offset      = feat_r[8];
    out_item.zero_height           = zero_r;
  end
endmodule
`default_nettype wire

// ----- design/symbol_box_relation_features_top.sv -----
// ----------------------------------------------------------------------------
// symbol_box_relation_features_top
// Box and centroid relation features between two ink symbols.
// ----------------------------------------------------------------------------
// Usage: drive in_item with start high while busy is low; the point is taken
// at that edge. Reference symbol points come in slot 0, then compared symbol
// points in slot 1, each symbol closed by last_point.
// An ordinary point is captured, then the box and accumulator are updated.
// A last point adds the centroid division: one quotient bit per cycle in the
// shared restoring divider of DW bits (DW is 32 at the defaults).
// A compared symbol's last point then runs nine feature divisions through
// that same divider, and out_valid pulses for one cycle with out_item; the
// boxes, centroids and accumulator then return to their reset values.
// The receiver cannot stall: a result is shown for exactly one cycle.
// Synchronous active-low reset clears the boxes, centroids and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module symbol_box_relation_features_top #(
  parameter int MAX_POINTS        = sbrf_pkg::MAX_POINTS_DEF,
  parameter int FEATURE_FRAC_BITS = sbrf_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  sbrf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output sbrf_pkg::out_item_t out_item
);
  import sbrf_pkg::*;

  sbrf_cmd_t  cmd;
  sbrf_sts_t  sts;
  logic [3:0] feat_idx;
  logic       valid_r;

  sbrf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd), .feat_idx(feat_idx)
  );

  sbrf_dp #(
    .MAX_POINTS(MAX_POINTS),
    .FEATURE_FRAC_BITS(FEATURE_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .load(start && !busy), .in_item(in_item),
    .cmd(cmd), .feat_idx(feat_idx), .sts(sts), .out_item(out_item)
  );

  // features are held until the next feature store, so pulse in the cycle after emit
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= cmd.emit;
  end
  assign out_valid = valid_r;
endmodule
`default_nettype wire

// ----- design/sbrf_checker.sv -----
// ----------------------------------------------------------------------------
// sbrf_checker
// Port-level checks on the feature block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sbrf_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input sbrf_pkg::out_item_t out_item
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accepted transfer");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
  a_idle_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_zero_feats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_height |-> out_item.height_ratio == 16'd0 &&
    out_item.high_edge_offset == 16'd0) else $error("zero height with features");
endmodule

bind symbol_box_relation_features_top sbrf_checker u_sbrf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Feeds ink points of symbol pairs into symbol_box_relation_features_top and
// checks each feature result against a behavioural predictor of boxes,
// centroids and saturated Q8.8 ratios; directed rows first, then random pairs.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbrf_pkg::*;

  localparam int MAXPTS    = 4096;
  localparam int CYC_LIMIT = 900000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  symbol_box_relation_features_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  longint bmin_x[2], bmax_x[2], bmin_y[2], bmax_y[2], cent[2];
  longint ysum;
  int     npts;

  out_item_t feat_q[$];
  int        errors = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        zero_h_seen = 0;
  longint    cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic void clear_boxes();
    for (int i = 0; i < 2; i++) begin
      bmin_x[i] = 32767; bmin_y[i] = 32767;
      bmax_x[i] = -32768; bmax_y[i] = -32768;
      cent[i] = 0;
    end
    ysum = 0;
    npts = 0;
  endfunction

  function automatic longint fdiv(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic logic signed [15:0] q88(input longint num, input longint den);
    longint sc, mag, q;
    sc = num * 256;
    mag = sc < 0 ? -sc : sc;
    q = (2 * mag + den) / (2 * den);
    if (sc < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // returns 1 and fills f when this point closes a compared symbol
  function automatic bit predict_features(input in_item_t it, output out_item_t f);
    longint x, y, c, h, top, bot;
    int s;
    x = it.point_x;
    y = it.point_y;
    s = it.slot;
    f = '0;
    if (x < bmin_x[s]) bmin_x[s] = x;
    if (x > bmax_x[s]) bmax_x[s] = x;
    if (y < bmin_y[s]) bmin_y[s] = y;
    if (y > bmax_y[s]) bmax_y[s] = y;
    if (npts < MAXPTS) begin
      ysum += y;
      npts++;
    end
    if (!it.last_point) return 0;
    c = (npts == 0) ? 0 : fdiv(2 * ysum + npts, 2 * npts);
    case (it.symbol_class)
      CLS_ASCEND:  c = fdiv(c + bmax_y[s], 2);
      CLS_DESCEND: c = fdiv(c + bmin_y[s], 2);
      CLS_MIDDLE:  c = fdiv(bmin_y[s] + bmax_y[s], 2);
      default:     ;
    endcase
    cent[s] = c;
    ysum = 0;
    npts = 0;
    if (s == 0) return 0;
    top = bmax_y[0] > bmax_y[1] ? bmax_y[0] : bmax_y[1];
    bot = bmin_y[0] < bmin_y[1] ? bmin_y[0] : bmin_y[1];
    h = top - bot;
    if (h <= 0) begin
      f.zero_height = 1'b1;
    end else begin
      f.height_ratio          = q88(bmax_y[1] - bmin_y[1] + 16, h);
      f.centroid_offset       = q88(cent[0] - cent[1], h);
      f.half_width_difference = q88((bmax_x[0] - bmin_x[0]) - (bmax_x[1] - bmin_x[1]), 2 * h);
      f.horizontal_gap        = q88(bmin_x[1] - bmax_x[0], h);
      f.left_offset           = q88(bmin_x[1] - bmin_x[0], h);
      f.right_offset          = q88(bmax_x[1] - bmax_x[0], h);
      f.vertical_gap          = q88(bmin_y[1] - bmax_y[0], h);
      f.low_edge_offset       = q88(bmin_y[1] - bmin_y[0], h);
      f.high_edge_offset      = q88(bmax_y[1] - bmax_y[0], h);
    end
    clear_boxes();
    return 1;
  endfunction

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (feat_q.size() == 0) begin
        $display("unexpected result %0d", results_seen);
        errors++;
      end else begin
        out_item_t w;
        w = feat_q.pop_front();
        if (w.zero_height) zero_h_seen++;
        if (out_item.height_ratio !== w.height_ratio)
          report_mismatch("height_ratio", out_item.height_ratio, w.height_ratio);
        if (out_item.centroid_offset !== w.centroid_offset)
          report_mismatch("centroid_offset", out_item.centroid_offset, w.centroid_offset);
        if (out_item.half_width_difference !== w.half_width_difference)
          report_mismatch("half_width_difference", out_item.half_width_difference,
                          w.half_width_difference);
        if (out_item.horizontal_gap !== w.horizontal_gap)
          report_mismatch("horizontal_gap", out_item.horizontal_gap, w.horizontal_gap);
        if (out_item.left_offset !== w.left_offset)
          report_mismatch("left_offset", out_item.left_offset, w.left_offset);
        if (out_item.right_offset !== w.right_offset)
          report_mismatch("right_offset", out_item.right_offset, w.right_offset);
        if (out_item.vertical_gap !== w.vertical_gap)
          report_mismatch("vertical_gap", out_item.vertical_gap, w.vertical_gap);
        if (out_item.low_edge_offset !== w.low_edge_offset)
          report_mismatch("low_edge_offset", out_item.low_edge_offset, w.low_edge_offset);
        if (out_item.high_edge_offset !== w.high_edge_offset)
          report_mismatch("high_edge_offset", out_item.high_edge_offset, w.high_edge_offset);
        if (out_item.zero_height !== w.zero_height)
          report_mismatch("zero_height", out_item.zero_height, w.zero_height);
      end
    end
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("symbol_box_relation_features_top verification failed");
      $finish;
    end
  end

  bit quiet_stretch;

  // one point transfer, with a random idle gap in front
  task automatic send_point(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t f;
    bit has;
    while (!quiet_stretch && $urandom_range(99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    has = predict_features(it, f);
    if (has) feat_q.push_back(typed ? typed_res : f);
    items_sent++;
  endtask

  function automatic in_item_t mk(input logic signed [15:0] x, input logic signed [15:0] y,
                                  input logic s, input logic [1:0] c, input logic l);
    in_item_t it;
    it.point_x = x; it.point_y = y; it.slot = s; it.symbol_class = c; it.last_point = l;
    return it;
  endfunction

  function automatic logic signed [15:0] rnd_coord(input int spread);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'($urandom());
    return 16'($urandom_range(2 * spread) - spread);
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  row_t      rows[$];
  out_item_t zero_res;
  out_item_t sat_res;

  initial begin
    int pairs;
    int spread, n0, n1, cx, cy;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    quiet_stretch = 0;
    clear_boxes();
    zero_res = '0;
    zero_res.zero_height = 1'b1;
    // compared symbol alone, one unit high: reference box still at reset
    sat_res = '0;
    sat_res.height_ratio          = 16'sd512;
    sat_res.centroid_offset       = -16'sd128;
    sat_res.half_width_difference = -16'sd32768;
    sat_res.horizontal_gap        = 16'sd32767;
    sat_res.left_offset           = -16'sd32768;
    sat_res.right_offset          = 16'sd32767;
    sat_res.vertical_gap          = 16'sd32767;
    sat_res.low_edge_offset       = -16'sd32768;
    sat_res.high_edge_offset      = 16'sd32767;
    // single point compared symbol, same y for both: zero joint height
    rows.push_back('{mk(16'sd0, 16'sd100, 1'b0, CLS_MEAN, 1'b1), 0, '0});
    rows.push_back('{mk(16'sd50, 16'sd100, 1'b1, CLS_MEAN, 1'b1), 1, zero_res});
    // extremes of the coordinates, every class
    rows.push_back('{mk(16'sh8000, 16'sh8000, 1'b0, CLS_MEAN, 1'b0), 0, '0});
    rows.push_back('{mk(16'sh7fff, 16'sh7fff, 1'b0, CLS_ASCEND, 1'b1), 0, '0});
    rows.push_back('{mk(16'sh7fff, 16'sh8000, 1'b1, CLS_DESCEND, 1'b0), 0, '0});
    rows.push_back('{mk(16'sh8000, 16'sh7fff, 1'b1, CLS_MIDDLE, 1'b1), 0, '0});
    // interleaved slots, reference extended after its end
    rows.push_back('{mk(-16'sd40, 16'sd30, 1'b0, CLS_DESCEND, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd10, -16'sd25, 1'b1, CLS_ASCEND, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd20, 16'sd75, 1'b0, CLS_DESCEND, 1'b1), 0, '0});
    rows.push_back('{mk(16'sd90, 16'sd5, 1'b0, CLS_MEAN, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd33, 16'sd47, 1'b1, CLS_ASCEND, 1'b1), 0, '0});
    // compared symbol alone, ratios against the reset box saturate
    rows.push_back('{mk(16'sd0, 16'sd0, 1'b1, CLS_MEAN, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd0, 16'sd16, 1'b1, CLS_MEAN, 1'b1), 1, sat_res});
    // rounding ties of the mean
    rows.push_back('{mk(16'sd1, -16'sd3, 1'b0, CLS_MEAN, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd2, -16'sd2, 1'b0, CLS_MIDDLE, 1'b1), 0, '0});
    rows.push_back('{mk(16'sd7, 16'sd1, 1'b1, CLS_MEAN, 1'b0), 0, '0});
    rows.push_back('{mk(16'sd9, 16'sd4, 1'b1, CLS_MEAN, 1'b1), 0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_point(rows[i].it, rows[i].typed, rows[i].res);

    pairs = 0;
    while (items_sent < 1100) begin
      quiet_stretch = (pairs >= 20 && pairs < 35);
      spread = ($urandom_range(7) == 0) ? 32767 : $urandom_range(1, 2000);
      cx = $urandom_range(4000) - 2000;
      cy = $urandom_range(4000) - 2000;
      n0 = $urandom_range(1, 6);
      n1 = $urandom_range(1, 6);
      if ($urandom_range(9) == 0) begin
        // noise: random slots and ends
        repeat ($urandom_range(1, 6))
          send_point(mk(rnd_coord(spread), rnd_coord(spread), 1'($urandom_range(1)),
                        2'($urandom_range(3)), $urandom_range(3) == 0), 0, '0);
      end else begin
        for (int k = 0; k < n0; k++)
          send_point(mk(16'(rnd_coord(spread) + cx), 16'(rnd_coord(spread) + cy), 1'b0,
                        2'($urandom_range(3)), k == n0 - 1), 0, '0);
        for (int k = 0; k < n1; k++)
          send_point(mk(16'(rnd_coord(spread) - cx), 16'(rnd_coord(spread) - cy), 1'b1,
                        2'($urandom_range(3)), k == n1 - 1), 0, '0);
      end
      pairs++;
    end
    send_point(mk(16'sd3, 16'sd9, 1'b1, CLS_ASCEND, 1'b1), 0, '0);
    start <= 1'b0;

    while (feat_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("sent %0d points, checked %0d feature results (%0d with zero height)",
             items_sent, results_seen, zero_h_seen);
    if (errors == 0)
      $display("symbol_box_relation_features_top verification clean");
    else
      $display("symbol_box_relation_features_top verification failed");
    $finish;
  end
endmodule
